// File: design/angle_pid_deadband_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle PID controller
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANGLE_PID_DEADBAND_CONTROLLER_ASSERT_SVH
`define ANGLE_PID_DEADBAND_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define APID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define APID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/apid_pkg.sv
// ----------------------------------------------------------------------------
// apid_pkg
// Widths, constants, codes and the command/status types shared by the
// angle PID controller modules.
// ----------------------------------------------------------------------------
package apid_pkg;

    // Fixed-point format of angles and the integral width
    localparam int FRAC_BITS = 8;
    localparam int SUM_WIDTH = 32;
    localparam int GAIN_FRAC = 8;

    // Field and register widths
    localparam int GAIN_W     = 12;
    localparam int DB_W       = 16;
    localparam int CPR_W      = 16;
    localparam int LIM_W      = 8;
    localparam int RAW_W      = 10;
    localparam int ENC_W      = 32;
    localparam int TGT_W      = 9;
    localparam int DUTY_W     = 8;
    localparam int PID_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_FIELDS_W = DUTY_W + 2 + PID_W + 2;

    // Angle constants
    localparam int DEG_PER_REV = 360;
    localparam int HALF_TURN   = 179;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(166);
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(18);
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(512);
    localparam logic [DB_W-1:0]   DEADBAND_RST   = DB_W'(1280);
    localparam logic [CPR_W-1:0]  CPR_RST        = CPR_W'(709);
    localparam logic [LIM_W-1:0]  LIMIT_RST      = LIM_W'(255);

    // Derived datapath widths
    localparam int POS_W  = FRAC_BITS + 10;
    localparam int ERR_W  = FRAC_BITS + 11;
    localparam int DERR_W = ERR_W + 1;
    localparam int DIVD_RAW = (FRAC_BITS + CPR_W + 9 > ENC_W) ?
                              FRAC_BITS + CPR_W + 9 : ENC_W;
    localparam int DIVD_W = DIVD_RAW + (DIVD_RAW % 2);
    localparam int MUL_W  = (SUM_WIDTH > DERR_W) ? SUM_WIDTH : DERR_W;
    localparam int PROD_W = GAIN_W + 1 + MUL_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SCALE_SH = FRAC_BITS + GAIN_FRAC;
    localparam int CMP_W  = ((ERR_W > DB_W + 1) ? ERR_W : DB_W + 1) + 1;
    localparam int SADD_W = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;

    // Item kinds on the input tuser
    localparam logic MODE_SETPT = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_INTEG = 3'd1,
        CFG_GAIN_DERIV = 3'd2,
        CFG_DEADBAND   = 3'd3,
        CFG_CPR        = 3'd4,
        CFG_LIMIT      = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_POS,
        S_DECIDE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_CLAMP,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_SETPT,
        RES_BRAKE,
        RES_DRIVE
    } res_sel_t;

    typedef enum logic [1:0] {
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
        logic [DB_W-1:0]   deadband;
        logic [CPR_W-1:0]  cpr;
        logic [LIM_W-1:0]  limit;
    } cfg_t;

    typedef struct packed {
        logic     take_setpt;
        logic     take_tick;
        logic     div_scale;
        logic     form_err;
        logic     decide;
        logic     mul_en;
        mul_op_t  mul_op;
        acc_op_t  acc_op;
        logic     clamp;
        logic     out_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic running;
        logic div_busy;
        logic loop_run;
    } status_t;

    // Result fields, last member in the lowest bits
    typedef struct packed {
        logic              encoder_clear;
        logic              active;
        logic [PID_W-1:0]  pid_value;
        logic              dir_b;
        logic              dir_a;
        logic [DUTY_W-1:0] drive_duty;
    } result_t;

endpackage

// File: design/angle_pid_deadband_controller.sv
// ----------------------------------------------------------------------------
// angle_pid_deadband_controller
// Setpoint items and idle ticks go straight to the output state. Running
// ticks pass through two divider passes of 17 two-bit steps each and,
// while the loop runs, three products on one multiplier before the clamp
// and output. A stalled output holds the sequencer. One item in flight at
// a time.
// Reset (async, rst_n low) restores the register defaults and clears state.
// ----------------------------------------------------------------------------
`include "angle_pid_deadband_controller_assert.svh"

module angle_pid_deadband_controller
    import apid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input item stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // setpoint_raw[9:0], encoder_count[41:10]
    input  logic [0:0]            s_axis_tuser,   // mode[0]
    // Result item stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // drive_duty[7:0], dir_a[8], dir_b[9],
                                                  // pid_value[18:10], active[19],
                                                  // encoder_clear[20]
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop  <= GAIN_PROP_RST;
            cfg_reg.gain_integ <= GAIN_INTEG_RST;
            cfg_reg.gain_deriv <= GAIN_DERIV_RST;
            cfg_reg.deadband   <= DEADBAND_RST;
            cfg_reg.cpr        <= CPR_RST;
            cfg_reg.limit      <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_idx))
                CFG_GAIN_PROP:  cfg_reg.gain_prop  <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_INTEG: cfg_reg.gain_integ <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_DERIV: cfg_reg.gain_deriv <= cfg_wdata[GAIN_W-1:0];
                CFG_DEADBAND:   cfg_reg.deadband   <= cfg_wdata[DB_W-1:0];
                CFG_CPR:        cfg_reg.cpr        <= cfg_wdata[CPR_W-1:0];
                CFG_LIMIT:      cfg_reg.limit      <= cfg_wdata[LIM_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    apid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    apid_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg_reg),
        .setpoint_raw  (s_axis_tdata[RAW_W-1:0]),
        .encoder_count (s_axis_tdata[RAW_W+ENC_W-1:RAW_W]),
        .result        (result)
    );

    // Output register: hold the item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_reg};

    `APID_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_reg || m_axis_tready, "result loaded over a pending item")
    `APID_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item accepted while one is in work")

endmodule

// File: design/apid_div.sv
// ----------------------------------------------------------------------------
// apid_div
// Unsigned restoring divider, two quotient bits per cycle. Gives quotient
// and remainder of a DIVD_W-bit dividend by a nonzero CPR_W-bit divisor.
// ----------------------------------------------------------------------------
`include "angle_pid_deadband_controller_assert.svh"

module apid_div
    import apid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [CPR_W-1:0]  divisor,
    output logic              busy,
    output logic [DIVD_W-1:0] quotient,
    output logic [CPR_W-1:0]  remainder
);

    localparam int DIV_ITER = DIVD_W / 2;
    localparam int ITER_W   = $clog2(DIV_ITER + 1);

    logic              busy_reg, busy_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CPR_W-1:0]  rem_reg, rem_next;
    logic [CPR_W-1:0]  dsr_reg;

    // Two compare-and-subtract steps per cycle
    always_comb
    begin
        logic [CPR_W:0] trial;
        logic [CPR_W:0] diff;
        logic           ge;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_next, quo_next[DIVD_W-1]};
            diff     = trial - {1'b0, dsr_reg};
            ge       = (trial >= {1'b0, dsr_reg});
            quo_next = {quo_next[DIVD_W-2:0], ge};
            rem_next = ge ? diff[CPR_W-1:0] : trial[CPR_W-1:0];
        end
    end

    // Iteration count and busy flag
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ITER_W'(DIV_ITER);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Load operands on start, shift while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `APID_ASSERT_NEXT(a_div_start_busy, start, busy_reg, "divider did not go busy on start")
    `APID_ASSERT_NOW(a_div_rem_range, busy_reg, rem_reg < dsr_reg, "partial remainder not below divisor")

endmodule

// File: design/apid_dpath.sv
// ----------------------------------------------------------------------------
// apid_dpath
// Datapath of the angle PID controller: setpoint wrap, encoder modulo and
// scaling through a shared divider, error terms, saturating integral, one
// shared multiplier with accumulator, clamp and result formatting.
// ----------------------------------------------------------------------------
`include "angle_pid_deadband_controller_assert.svh"

module apid_dpath
    import apid_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output status_t          status,
    input  cfg_t             cfg,
    input  logic [RAW_W-1:0] setpoint_raw,
    input  logic [ENC_W-1:0] encoder_count,
    output result_t          result
);

    localparam logic signed [RAW_W:0] SP_WRAP_AT = (RAW_W+1)'(HALF_TURN);
    localparam logic signed [RAW_W:0] SP_REV     = (RAW_W+1)'(DEG_PER_REV);
    localparam logic signed [RAW_W:0] TGT_HI     = (RAW_W+1)'(2**(TGT_W-1) - 1);
    localparam logic signed [RAW_W:0] TGT_LO     = -(RAW_W+1)'(2**(TGT_W-1));
    localparam logic signed [SADD_W-1:0] SUM_MAX =
        {{(SADD_W-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SADD_W-1:0] SUM_MIN =
        {{(SADD_W-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_ADD =
        {{(ACC_W-SCALE_SH){1'b0}}, {SCALE_SH{1'b1}}};

    // Loop state
    logic signed [TGT_W-1:0]     target_reg;
    logic                        running_reg;
    logic signed [ERR_W-1:0]     prev_err_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg;

    // Per-tick working registers
    logic                        enc_neg_reg;
    logic signed [ERR_W-1:0]     err_reg, err_next;
    logic signed [DERR_W-1:0]    derr_reg, derr_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [PID_W-1:0]     pid_reg, pid_next;
    logic                        fwd_reg, fwd_next;

    logic signed [RAW_W:0]       sp_wide, sp_wrap;
    logic signed [TGT_W-1:0]     sp_sat;
    logic [ENC_W-1:0]            enc_mag;
    logic [CPR_W-1:0]            cpr_eff;
    logic [DIVD_W-1:0]           scaled, div_dividend, div_quo;
    logic [CPR_W-1:0]            div_rem;
    logic                        div_start, div_busy;
    logic [POS_W-2:0]            pos_mag;
    logic signed [POS_W-1:0]     pos;
    logic signed [ERR_W-1:0]     tgt_q;
    logic signed [CMP_W-1:0]     err_c, db_c;
    logic                        loop_run;
    logic signed [SADD_W-1:0]    sadd;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic [GAIN_W-1:0]           mul_gain;
    logic signed [MUL_W-1:0]     mul_val;
    logic signed [ACC_W-1:0]     prod_ext, lim, clamped, rounded, ival;
    logic signed [PID_W-1:0]     pid_mag;

    // Setpoint wrap to the signed half turn, then saturate to the target range
    always_comb
    begin
        sp_wide = {setpoint_raw[RAW_W-1], setpoint_raw};
        sp_wrap = (sp_wide > SP_WRAP_AT) ? sp_wide - SP_REV : sp_wide;
        if (sp_wrap > TGT_HI)
        begin
            sp_sat = TGT_HI[TGT_W-1:0];
        end
        else if (sp_wrap < TGT_LO)
        begin
            sp_sat = TGT_LO[TGT_W-1:0];
        end
        else
        begin
            sp_sat = sp_wrap[TGT_W-1:0];
        end
    end

    // Divider operands: encoder magnitude first, then scaled remainder
    assign enc_mag = encoder_count[ENC_W-1] ? (~encoder_count + 1'b1) : encoder_count;
    assign cpr_eff = (cfg.cpr == '0) ? CPR_W'(1) : cfg.cpr;
    assign scaled  = (DIVD_W'(div_rem) * DIVD_W'(DEG_PER_REV)) << FRAC_BITS;
    assign div_start    = cmd.take_tick | cmd.div_scale;
    assign div_dividend = cmd.take_tick ? DIVD_W'(enc_mag) : scaled;

    apid_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (cpr_eff),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Position, error and error difference
    always_comb
    begin
        pos_mag   = div_quo[POS_W-2:0];
        pos       = enc_neg_reg ? -$signed({1'b0, pos_mag}) : $signed({1'b0, pos_mag});
        tgt_q     = {{(ERR_W-TGT_W-FRAC_BITS){target_reg[TGT_W-1]}}, target_reg,
                     {FRAC_BITS{1'b0}}};
        err_next  = tgt_q - {{(ERR_W-POS_W){pos[POS_W-1]}}, pos};
        derr_next = {err_next[ERR_W-1], err_next} - {prev_err_reg[ERR_W-1], prev_err_reg};
    end

    // Deadband test and saturating integral
    always_comb
    begin
        err_c    = {{(CMP_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
        db_c     = {{(CMP_W-DB_W){1'b0}}, cfg.deadband};
        loop_run = (err_c > db_c) || ((err_c < -db_c) && (target_reg != '0));
        sadd     = {{(SADD_W-SUM_WIDTH){sum_reg[SUM_WIDTH-1]}}, sum_reg}
                 + {{(SADD_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
        if (sadd > SUM_MAX)
        begin
            sum_sat = SUM_MAX[SUM_WIDTH-1:0];
        end
        else if (sadd < SUM_MIN)
        begin
            sum_sat = SUM_MIN[SUM_WIDTH-1:0];
        end
        else
        begin
            sum_sat = sadd[SUM_WIDTH-1:0];
        end
    end

    // Multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            MUL_PROP:
            begin
                mul_gain = cfg.gain_prop;
                mul_val  = {{(MUL_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            MUL_INTEG:
            begin
                mul_gain = cfg.gain_integ;
                mul_val  = {{(MUL_W-SUM_WIDTH){sum_reg[SUM_WIDTH-1]}}, sum_reg};
            end
            MUL_DERIV:
            begin
                mul_gain = cfg.gain_deriv;
                mul_val  = {{(MUL_W-DERR_W){derr_reg[DERR_W-1]}}, derr_reg};
            end
            default:
            begin
                mul_gain = '0;
                mul_val  = '0;
            end
        endcase
    end

    // Clamp to the drive limit and truncate toward zero
    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        lim      = {{(ACC_W-LIM_W-SCALE_SH){1'b0}}, cfg.limit, {SCALE_SH{1'b0}}};
        if (acc_reg > lim)
        begin
            clamped = lim;
        end
        else if (acc_reg < -lim)
        begin
            clamped = -lim;
        end
        else
        begin
            clamped = acc_reg;
        end
        rounded  = clamped[ACC_W-1] ? clamped + ROUND_ADD : clamped;
        ival     = rounded >>> SCALE_SH;
        pid_next = ival[PID_W-1:0];
        // Forward only for a strictly positive sum
        fwd_next = !acc_reg[ACC_W-1] && (acc_reg != '0);
    end

    // Loop state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            running_reg  <= 1'b0;
            prev_err_reg <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            if (cmd.take_setpt)
            begin
                target_reg  <= sp_sat;
                running_reg <= 1'b1;
            end
            if (cmd.form_err)
            begin
                prev_err_reg <= err_next;
            end
            if (cmd.decide)
            begin
                if (loop_run)
                begin
                    sum_reg <= sum_sat;
                end
                else
                begin
                    sum_reg     <= '0;
                    running_reg <= 1'b0;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_tick)
        begin
            enc_neg_reg <= encoder_count[ENC_W-1];
        end
        if (cmd.form_err)
        begin
            err_reg  <= err_next;
            derr_reg <= derr_next;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= $signed({1'b0, mul_gain}) * mul_val;
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:  acc_reg <= acc_reg;
        endcase
        if (cmd.clamp)
        begin
            pid_reg <= pid_next;
            fwd_reg <= fwd_next;
        end
    end

    // Result formatting
    always_comb
    begin
        pid_mag = pid_reg[PID_W-1] ? -pid_reg : pid_reg;
        result  = '0;
        case (cmd.res_sel)
            RES_ZERO:
            begin
                result = '0;
            end
            RES_SETPT:
            begin
                result.active        = 1'b1;
                result.encoder_clear = 1'b1;
            end
            RES_BRAKE:
            begin
                result.dir_a         = 1'b1;
                result.dir_b         = 1'b1;
                result.encoder_clear = 1'b1;
            end
            RES_DRIVE:
            begin
                result.drive_duty = pid_mag[DUTY_W-1:0];
                result.dir_a      = fwd_reg;
                result.dir_b      = ~fwd_reg;
                result.pid_value  = pid_reg;
                result.active     = 1'b1;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    assign status.running  = running_reg;
    assign status.div_busy = div_busy;
    assign status.loop_run = loop_run;

    `APID_ASSERT_NEXT(a_stop_clears, cmd.decide && !loop_run, !running_reg && (sum_reg == '0), "loop stop did not clear running and integral")

endmodule

// File: design/apid_ctrl.sv
// ----------------------------------------------------------------------------
// apid_ctrl
// Sequencer of the angle PID controller. Takes one item at a time, steps
// the datapath through modulo, scaling, error, decision, multiply and clamp,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module apid_ctrl
    import apid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_mode,
    output logic    in_ready,
    input  logic    out_free,
    input  status_t status,
    output cmd_t    cmd
);

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == MODE_SETPT)
                    begin
                        state_next   = S_OUT;
                        res_sel_next = RES_SETPT;
                    end
                    else if (status.running)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next   = S_OUT;
                        res_sel_next = RES_ZERO;
                    end
                end
            end
            S_MOD:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.loop_run)
                begin
                    state_next = S_MUL_P;
                end
                else
                begin
                    state_next   = S_OUT;
                    res_sel_next = RES_BRAKE;
                end
            end
            S_MUL_P: state_next = S_MUL_I;
            S_MUL_I: state_next = S_MUL_D;
            S_MUL_D: state_next = S_ACC;
            S_ACC:   state_next = S_CLAMP;
            S_CLAMP:
            begin
                state_next   = S_OUT;
                res_sel_next = RES_DRIVE;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd         = '0;
        cmd.res_sel = res_sel_reg;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.take_setpt = in_valid && (in_mode == MODE_SETPT);
                cmd.take_tick  = in_valid && (in_mode == MODE_TICK) && status.running;
            end
            S_MOD:
            begin
                cmd.div_scale = !status.div_busy;
            end
            S_POS:
            begin
                cmd.form_err = !status.div_busy;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            S_MUL_P:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_PROP;
            end
            S_MUL_I:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_INTEG;
                cmd.acc_op = ACC_LOAD;
            end
            S_MUL_D:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_DERIV;
                cmd.acc_op = ACC_ADD;
            end
            S_ACC:
            begin
                cmd.acc_op = ACC_ADD;
            end
            S_CLAMP:
            begin
                cmd.clamp = 1'b1;
            end
            S_OUT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            res_sel_reg <= RES_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle PID controller testbench
// Drives setpoint and tick items into the controller, predicts every result
// item from its own copy of the loop state and configuration, and compares
// each received item field by field. A directed table comes first, then
// random setpoint/tick sequences under several register settings, then a
// long unstalled run of ticks far from the target.
// ----------------------------------------------------------------------------
module testbench;
    import apid_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_DIRECTED  = 24;
    localparam int BURST_TICKS = 200;

    // Fixed expectations that follow directly from the command alone
    localparam result_t EXP_IDLE     = '0;
    localparam result_t EXP_SETPOINT = '{1'b1, 1'b1, 9'd0, 1'b0, 1'b0, 8'd0};
    localparam result_t EXP_BRAKE    = '{1'b1, 1'b0, 9'd0, 1'b1, 1'b1, 8'd0};

    typedef struct packed {
        logic             mode;
        logic [RAW_W-1:0] raw;
        logic [ENC_W-1:0] enc;
        logic             fixed_want;
        result_t          want;
    } stim_row_t;

    // Directed items: reset state, angle wrap, extremes, deadband edges
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{MODE_TICK,  10'd0,        32'd0,          1'b1, EXP_IDLE},
        '{MODE_SETPT, 10'd0,        32'd0,          1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'd0,        32'd0,          1'b1, EXP_BRAKE},
        '{MODE_TICK,  10'd0,        32'd12345,      1'b1, EXP_IDLE},
        '{MODE_SETPT, 10'd0,        32'd0,          1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'd0,        32'd300,        1'b1, EXP_BRAKE},
        '{MODE_SETPT, 10'd0,        32'd0,          1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'd0,        -32'sd300,      1'b0, EXP_IDLE},
        '{MODE_SETPT, 10'd359,      32'hFFFF_FFFF,  1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'd0,        32'd0,          1'b1, EXP_BRAKE},
        '{MODE_SETPT, 10'd180,      32'd0,          1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'h3FF,      32'd0,          1'b0, EXP_IDLE},
        '{MODE_TICK,  10'd0,        32'h7FFF_FFFF,  1'b0, EXP_IDLE},
        '{MODE_TICK,  10'd0,        32'h8000_0000,  1'b0, EXP_IDLE},
        '{MODE_SETPT, -10'sd180,    32'd0,          1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'd0,        32'd354,        1'b0, EXP_IDLE},
        '{MODE_SETPT, 10'd179,      32'd0,          1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'd0,        -32'sd1,        1'b0, EXP_IDLE},
        '{MODE_TICK,  10'd0,        32'd709,        1'b0, EXP_IDLE},
        '{MODE_TICK,  10'd0,        32'd352,        1'b1, EXP_BRAKE},
        '{MODE_SETPT, 10'd90,       32'd0,          1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'd0,        32'd100,        1'b0, EXP_IDLE},
        '{MODE_SETPT, -10'sd90,     32'd0,          1'b1, EXP_SETPOINT},
        '{MODE_TICK,  10'd0,        -32'sd100,      1'b0, EXP_IDLE}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // setpoint_raw[9:0], encoder_count[41:10]
    logic [0:0]            s_axis_tuser = '0;   // mode[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // drive_duty[7:0], dir_a[8], dir_b[9],
                                                // pid_value[18:10], active[19],
                                                // encoder_clear[20]
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Register copies
    logic [GAIN_W-1:0] kp_reg    = GAIN_PROP_RST;
    logic [GAIN_W-1:0] ki_reg    = GAIN_INTEG_RST;
    logic [GAIN_W-1:0] kd_reg    = GAIN_DERIV_RST;
    logic [DB_W-1:0]   band_reg  = DEADBAND_RST;
    logic [CPR_W-1:0]  cpr_reg   = CPR_RST;
    logic [LIM_W-1:0]  limit_reg = LIMIT_RST;

    // Loop state copies
    longint target_deg   = 0;
    longint last_err     = 0;
    longint integ        = 0;
    bit     loop_running = 1'b0;

    result_t pending_drive [$];
    int      fail_count  = 0;
    int      item_count  = 0;
    int      cycle_count = 0;
    bit      no_idle     = 1'b0;

    angle_pid_deadband_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Work out the drive result of one item and advance the loop state
    function automatic result_t predict_drive(input logic mode, input logic [RAW_W-1:0] raw,
                                              input logic [ENC_W-1:0] enc);
        result_t r;
        longint  t, cpr_eff, rem, pos, err, derr, band, s, smax, smin, pid, lim, scale, ival;
        longint  mag;
        r = EXP_IDLE;
        if (mode == MODE_SETPT)
        begin
            t = longint'($signed(raw));
            if (t > HALF_TURN)
                t = t - DEG_PER_REV;
            if (t > 255)
                t = 255;
            if (t < -256)
                t = -256;
            target_deg   = t;
            loop_running = 1'b1;
            return EXP_SETPOINT;
        end
        if (!loop_running)
            return r;

        // Reduce the count to one revolution and scale to Q.8 degrees
        cpr_eff  = (cpr_reg == 0) ? 1 : longint'(cpr_reg);
        rem      = longint'($signed(enc)) % cpr_eff;
        pos      = (rem * DEG_PER_REV * (longint'(1) << FRAC_BITS)) / cpr_eff;
        err      = target_deg * (longint'(1) << FRAC_BITS) - pos;
        derr     = err - last_err;
        band     = longint'(band_reg);
        last_err = err;

        if (err > band || (err < -band && target_deg != 0))
        begin
            smax = (longint'(1) << (SUM_WIDTH - 1)) - 1;
            smin = -smax - 1;
            s = integ + err;
            if (s > smax)
                s = smax;
            if (s < smin)
                s = smin;
            integ = s;
            pid = longint'(kp_reg) * err + longint'(ki_reg) * s + longint'(kd_reg) * derr;
            if (pid > 0)
                r.dir_a = 1'b1;
            else
                r.dir_b = 1'b1;
            // Clamp to the drive limit, keep the integer part
            scale = longint'(1) << (FRAC_BITS + GAIN_FRAC);
            lim   = longint'(limit_reg) * scale;
            if (pid > lim)
                pid = lim;
            if (pid < -lim)
                pid = -lim;
            ival = pid / scale;
            mag  = (ival < 0) ? -ival : ival;
            r.drive_duty = mag[DUTY_W-1:0];
            r.pid_value  = ival[PID_W-1:0];
            r.active     = 1'b1;
        end
        else
        begin
            integ        = 0;
            loop_running = 1'b0;
            r            = EXP_BRAKE;
        end
        return r;
    endfunction

    // Offer one item, wait for it to be taken, queue its expected result
    task automatic send_item(input logic mode, input logic [RAW_W-1:0] raw,
                             input logic [ENC_W-1:0] enc, input bit use_fixed = 1'b0,
                             input result_t fixed = EXP_IDLE);
        result_t want;
        int      gap;
        if (!no_idle && $urandom_range(0, 99) < 17)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({enc, raw});
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        item_count++;
        want = predict_drive(mode, raw, enc);
        pending_drive.push_back(use_fixed ? fixed : want);
    endtask

    // Hold off until every result is back and the block is quiet
    task automatic wait_settled();
        s_axis_tvalid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_GAIN_PROP:  kp_reg    = val[GAIN_W-1:0];
            CFG_GAIN_INTEG: ki_reg    = val[GAIN_W-1:0];
            CFG_GAIN_DERIV: kd_reg    = val[GAIN_W-1:0];
            CFG_DEADBAND:   band_reg  = val[DB_W-1:0];
            CFG_CPR:        cpr_reg   = val[CPR_W-1:0];
            CFG_LIMIT:      limit_reg = val[LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int kp, input int ki, input int kd, input int band,
                              input int cpr, input int lim);
        write_reg(CFG_GAIN_PROP, CFG_DATA_W'(kp));
        write_reg(CFG_GAIN_INTEG, CFG_DATA_W'(ki));
        write_reg(CFG_GAIN_DERIV, CFG_DATA_W'(kd));
        write_reg(CFG_DEADBAND, CFG_DATA_W'(band));
        write_reg(CFG_CPR, CFG_DATA_W'(cpr));
        write_reg(CFG_LIMIT, CFG_DATA_W'(lim));
    endtask

    // Mostly setpoints followed by ticks that close in on the target,
    // with loose ticks and lone setpoints mixed in
    task automatic drive_random_traffic(input int quota);
        int     stop_at, kind, n_ticks, k;
        longint cpr_eff, base, w, cnt;
        stop_at = item_count + quota;
        while (item_count < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                send_item(MODE_SETPT, RAW_W'($urandom_range(0, 539) - 180), $urandom);
                n_ticks = $urandom_range(1, 12);
                for (k = 0; k < n_ticks; k++)
                begin
                    if (!loop_running && $urandom_range(0, 3) != 0)
                        break;
                    cpr_eff = (cpr_reg == 0) ? 1 : longint'(cpr_reg);
                    base    = target_deg * cpr_eff / DEG_PER_REV;
                    w       = cpr_eff >> $urandom_range(1, 12);
                    cnt     = base + longint'($urandom_range(0, 2 * w)) - w;
                    // Add whole turns on the target's side
                    if ($urandom_range(0, 3) == 0)
                    begin
                        if (target_deg < 0)
                            cnt = cnt - cpr_eff * $urandom_range(1, 1000);
                        else
                            cnt = cnt + cpr_eff * $urandom_range(1, 1000);
                    end
                    send_item(MODE_TICK, RAW_W'($urandom), cnt[ENC_W-1:0]);
                end
            end
            else if (kind < 90)
                send_item(MODE_TICK, RAW_W'($urandom), $urandom);
            else
                send_item(MODE_SETPT, RAW_W'($urandom_range(0, 539) - 180), $urandom);
        end
    endtask

    // Compare one field of a result item
    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Check each result item against the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_FIELDS_W-1:0];
            if (pending_drive.size() == 0)
            begin
                $display("%0t: unexpected result item: expected none, got %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_drive.pop_front();
                compare_field("drive_duty", want.drive_duty, got.drive_duty);
                compare_field("dir_a", want.dir_a, got.dir_a);
                compare_field("dir_b", want.dir_b, got.dir_b);
                compare_field("pid_value", longint'($signed(want.pid_value)),
                              longint'($signed(got.pid_value)));
                compare_field("active", want.active, got.active);
                compare_field("encoder_clear", want.encoder_clear, got.encoder_clear);
            end
        end
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int row_idx;
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings
        for (row_idx = 0; row_idx < N_DIRECTED; row_idx++)
            send_item(DIRECTED_ROWS[row_idx].mode, DIRECTED_ROWS[row_idx].raw,
                      DIRECTED_ROWS[row_idx].enc, DIRECTED_ROWS[row_idx].fixed_want,
                      DIRECTED_ROWS[row_idx].want);
        wait_settled();

        drive_random_traffic(450);

        // Upper extremes: widest deadband, finest encoder
        wait_settled();
        set_config(4095, 4095, 4095, 65535, 65535, 255);
        drive_random_traffic(225);

        // Lower extremes: no gains, no deadband, zero counts per turn
        wait_settled();
        set_config(0, 0, 0, 0, 0, 1);
        drive_random_traffic(175);

        // Zero drive limit clamps everything
        wait_settled();
        set_config(4095, 0, 4095, 0, 1, 0);
        drive_random_traffic(75);

        // Assorted settings
        repeat (5)
        begin
            wait_settled();
            set_config($urandom_range(0, 4095), $urandom_range(0, 64), $urandom_range(0, 4095),
                       $urandom_range(0, 4000),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                   : $urandom_range(1, 65535),
                       $urandom_range(1, 255));
            drive_random_traffic(90);
        end

        // Run far from the target with no idling, integral growing each tick
        wait_settled();
        set_config($urandom_range(0, 4095), 4095, $urandom_range(0, 4095), 0, 65535,
                   $urandom_range(1, 255));
        no_idle = 1'b1;
        send_item(MODE_SETPT, RAW_W'(179), $urandom);
        for (n = 0; n < BURST_TICKS; n++)
            send_item(MODE_TICK, RAW_W'($urandom),
                      ENC_W'(-65534 - 65535 * longint'($urandom_range(0, 30000))));
        wait_settled();
        no_idle = 1'b0;

        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
